// File: rtl/core/hsh_pkg.sv
package hsh_pkg;

	localparam logic [31:0] KEY_LOW_RST  = 32'h0102_0304;
	localparam logic [31:0] KEY_HIGH_RST = 32'hfffe_fdfc;
	localparam logic [31:0] INIT_XOR_V2  = 32'h6c79_6765;
	localparam logic [31:0] INIT_XOR_V3  = 32'h7465_6462;
	localparam logic [31:0] FINAL_XOR    = 32'h0000_00ff;

	// Register indexes, taken from paddr[2].
	localparam logic REG_KEY_LOW  = 1'b0;
	localparam logic REG_KEY_HIGH = 1'b1;

	typedef struct packed {
		logic [31:0] v0;
		logic [31:0] v1;
		logic [31:0] v2;
		logic [31:0] v3;
	} sip_state_t;

	// State after the last byte word, plus the closing word to absorb.
	typedef struct packed {
		sip_state_t  st;
		logic [31:0] m;
	} fin_word_t;

	function automatic sip_state_t sip_round(input sip_state_t s);
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		sip_state_t  r;
		a = s.v0;
		b = s.v1;
		c = s.v2;
		d = s.v3;
		a = a + b;
		b = (b << 5) | (b >> 27);
		b = b ^ a;
		a = (a << 16) | (a >> 16);
		c = c + d;
		d = (d << 8) | (d >> 24);
		d = d ^ c;
		a = a + d;
		d = (d << 7) | (d >> 25);
		d = d ^ a;
		c = c + b;
		b = (b << 13) | (b >> 19);
		b = b ^ c;
		c = (c << 16) | (c >> 16);
		r.v0 = a;
		r.v1 = b;
		r.v2 = c;
		r.v3 = d;
		return r;
	endfunction

	function automatic sip_state_t sip_absorb(input sip_state_t s, input logic [31:0] m);
		sip_state_t t;
		t = s;
		t.v3 = t.v3 ^ m;
		t = sip_round(t);
		t.v0 = t.v0 ^ m;
		return t;
	endfunction

endpackage

// File: rtl/core/hsh_apb.sv
module hsh_apb
	import hsh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [31:0] key_low,
	output logic [31:0] key_high
);

	logic        wr_en;
	logic [31:0] key_low_q;
	logic [31:0] key_high_q;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= KEY_LOW_RST;
			key_high_q <= KEY_HIGH_RST;
		end else if (wr_en) begin
			case (paddr[2])
				REG_KEY_LOW:  key_low_q  <= pwdata;
				REG_KEY_HIGH: key_high_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_KEY_LOW:  prdata = key_low_q;
			REG_KEY_HIGH: prdata = key_high_q;
			default:      prdata = '0;
		endcase
	end

	assign key_low  = key_low_q;
	assign key_high = key_high_q;

endmodule

// File: rtl/core/hsh_absorb.sv
module hsh_absorb
	import hsh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  msg_byte,
	input  logic        byte_present,
	input  logic        end_of_message,
	input  logic [31:0] key_low,
	input  logic [31:0] key_high,
	output logic        fin_valid,
	input  logic        fin_ready,
	output fin_word_t   fin_word
);

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       present_s1;
	logic       end_s1;

	// Message state carried from word to word.
	logic        active_q;
	sip_state_t  sip_q;
	logic [31:0] accum_q;
	logic [1:0]  lane_q;
	logic [7:0]  len_q;

	sip_state_t  key_st;
	sip_state_t  base_st;
	sip_state_t  mixed_st;
	logic [31:0] base_acc;
	logic [1:0]  base_lane;
	logic [7:0]  base_len;
	logic [31:0] acc_n;
	logic [31:0] acc_after;
	logic [1:0]  lane_n;
	logic [7:0]  len_n;
	logic        word_done;
	logic        consume;
	logic        live;

	assign consume  = valid_s1 & (~end_s1 | fin_ready);
	assign in_stall = valid_s1 & ~consume;
	assign live     = present_s1 | end_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			byte_s1    <= msg_byte;
			present_s1 <= byte_present;
			end_s1     <= end_of_message;
		end
	end

	always_comb begin
		key_st.v0 = key_low;
		key_st.v1 = key_high;
		key_st.v2 = key_low ^ INIT_XOR_V2;
		key_st.v3 = key_high ^ INIT_XOR_V3;

		// A new message starts from the key and an empty word.
		base_st   = active_q ? sip_q : key_st;
		base_acc  = active_q ? accum_q : '0;
		base_lane = active_q ? lane_q : '0;
		base_len  = active_q ? len_q : '0;

		acc_n     = base_acc;
		lane_n    = base_lane;
		len_n     = base_len;
		word_done = 1'b0;
		if (present_s1) begin
			acc_n     = base_acc | ({24'b0, byte_s1} << {base_lane, 3'b000});
			lane_n    = base_lane + 2'd1;
			len_n     = base_len + 8'd1;
			word_done = (base_lane == 2'd3);
		end

		mixed_st  = word_done ? sip_absorb(base_st, acc_n) : base_st;
		acc_after = word_done ? '0 : acc_n;

		fin_word.st = mixed_st;
		fin_word.m  = acc_after | {len_n, 24'b0};
	end

	assign fin_valid = valid_s1 & end_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (consume && live) begin
			active_q <= ~end_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && live) begin
			sip_q   <= mixed_st;
			accum_q <= acc_after;
			lane_q  <= lane_n;
			len_q   <= len_n;
		end
	end

endmodule

// File: rtl/core/hsh_final.sv
module hsh_final
	import hsh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fin_valid,
	output logic        fin_ready,
	input  fin_word_t   fin_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] hash_value
);

	logic        valid_s1, valid_s2, valid_s3, valid_s4;
	fin_word_t   word_s1;
	sip_state_t  st_s2, st_s3, st_s4;
	logic        out_valid_q;
	logic [31:0] hash_q;

	logic        rdy_s2, rdy_s3, rdy_s4, rdy_out;
	sip_state_t  absorbed;
	sip_state_t  last_st;

	// A stage takes new data when it is empty or its content moves on.
	assign rdy_out   = ~out_valid_q | ~out_stall;
	assign rdy_s4    = ~valid_s4 | rdy_out;
	assign rdy_s3    = ~valid_s3 | rdy_s4;
	assign rdy_s2    = ~valid_s2 | rdy_s3;
	assign fin_ready = ~valid_s1 | rdy_s2;

	always_comb begin
		absorbed    = sip_absorb(word_s1.st, word_s1.m);
		absorbed.v2 = absorbed.v2 ^ FINAL_XOR;
		last_st     = sip_round(st_s4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_ready) valid_s1    <= fin_valid;
			if (rdy_s2)    valid_s2    <= valid_s1;
			if (rdy_s3)    valid_s3    <= valid_s2;
			if (rdy_s4)    valid_s4    <= valid_s3;
			if (rdy_out)   out_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_ready) word_s1 <= fin_word;
		if (rdy_s2)    st_s2   <= absorbed;
		if (rdy_s3)    st_s3   <= sip_round(st_s2);
		if (rdy_s4)    st_s4   <= sip_round(st_s3);
		if (rdy_out)   hash_q  <= last_st.v1 ^ last_st.v3;
	end

	assign out_valid  = out_valid_q;
	assign hash_value = hash_q;

endmodule

// File: rtl/core/halfsiphash_1_3_engine_core.sv
// HalfSipHash-1-3 engine with a 32-bit result, keyed by two 32-bit words.
// The input channel (in_valid, in_stall) takes one word per cycle: a message
// byte with its byte_present flag and an end_of_message flag. A word with
// neither flag set is ignored; a word with only end_of_message set closes a
// message, which may be empty. Bytes are packed little-endian, and every
// fourth byte costs one SipRound in the message state register, so any byte
// stream is taken at one word per clock.
// The end of a message hands the state to a four-stage finalisation pipeline
// (closing word, then three rounds), one round per stage, so several hashes
// may be in flight and a new message can follow in the very next cycle.
// The hash is presented on the output channel (out_valid, out_stall) after
// the closing word has passed the input register, the four finalisation
// stages and the output register, at a sustained rate of one word per cycle
// while out_stall is low. When the receiver stalls, the result holds in the
// output register and the stages behind it fill up before in_stall rises.
// The keys are written over the APB port (key_low at 0x0, key_high at 0x4)
// and are sampled by the first word of each message. Reset empties the
// pipeline, drops any half-read message and restores the default keys.
module halfsiphash_1_3_engine_core
	import hsh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,

	// byte channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  msg_byte,
	input  logic        byte_present,
	input  logic        end_of_message,

	// hash channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] hash_value
);

	logic [31:0] key_low;
	logic [31:0] key_high;
	logic        fin_valid;
	logic        fin_ready;
	fin_word_t   fin_word;

	// Key registers behind the APB port.
	hsh_apb u_apb (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.key_low  (key_low),
		.key_high (key_high)
	);

	// Byte packing and the per-word round; this is the only feedback loop.
	hsh_absorb u_absorb (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.msg_byte       (msg_byte),
		.byte_present   (byte_present),
		.end_of_message (end_of_message),
		.key_low        (key_low),
		.key_high       (key_high),
		.fin_valid      (fin_valid),
		.fin_ready      (fin_ready),
		.fin_word       (fin_word)
	);

	// Closing word, the final XOR and three rounds, then the output register.
	hsh_final u_final (
		.clk        (clk),
		.arst_n     (arst_n),
		.fin_valid  (fin_valid),
		.fin_ready  (fin_ready),
		.fin_word   (fin_word),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hash_value (hash_value)
	);

endmodule
